/* rtl/lcl_pkg.sv */
// Package for the longest increasing chain block.
// Holds the field widths and default parameters shared by the interfaces and the RTL.
package lcl_pkg;

    localparam int LCL_MAX_ITEMS = 512;
    localparam int LCL_RANK_BITS = 16;

    localparam int RANK_W = 16;
    localparam int LEN_W  = 10;
    localparam int IDX_W  = 9;

endpackage

/* rtl/lcl_if.sv */
// Valid/ready channel interfaces for the longest increasing chain block.
// Depends on lcl_pkg for the payload widths.
interface lcl_in_if import lcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              first_item;

    modport source (output valid, output rank, output first_item, input ready);
    modport sink (input valid, input rank, input first_item, output ready);
endinterface

interface lcl_out_if import lcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] chain_length;
    logic             has_prev;
    logic [IDX_W-1:0] prev_index;
    logic             overflow;

    modport source (output valid, output chain_length, output has_prev,
                    output prev_index, output overflow, input ready);
    modport sink (input valid, input chain_length, input has_prev,
                  input prev_index, input overflow, output ready);
endinterface

/* rtl/lcl_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module lcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/lis_chain_length_top.sv */
// Top level of the longest strictly increasing chain block.
// Depends on lcl_pkg, the channel interfaces in lcl_if.sv and the RAM lcl_ram.
//
// Usage: ranks arrive on i_in; first_item starts a new sequence. For each rank
// the block returns on o_out the longest strictly increasing chain ending at it,
// the earliest predecessor reaching that length, and an overflow flag when the
// store was already full and the rank was not kept.
// All stored ranks and chain lengths live in one RAM with a registered read.
// A rank is taken only while the block is idle. The scan then reads one stored
// element per cycle, every stored element of the sequence in index order, and
// the next rank is not taken until the scan and the load of its result are done.
// A first item or an empty sequence skips the scan and goes straight to the
// done state, from which its result is loaded into the output register.
// A result waits in an output register; the next rank is taken while it waits,
// and that rank's scan runs, but its result is held back until o_out transfers.
// Reset (i_rst_n low at a clock edge) empties the sequence and drops any result
// not yet transferred. The RAM needs no clearing: only written entries are read.
module lis_chain_length_top import lcl_pkg::*; #(
    parameter int MAX_ITEMS = LCL_MAX_ITEMS,
    parameter int RANK_BITS = LCL_RANK_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcl_in_if.sink     i_in,
    lcl_out_if.source  o_out
);

    localparam int RW = (RANK_BITS < RANK_W) ? RANK_BITS : RANK_W;
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int BW = LEN_W + 1;
    localparam int DW = RW + LEN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_issue;
    logic             r_pend;
    logic [IW-1:0]    r_pidx;
    logic [RW-1:0]    r_cur;
    logic [BW-1:0]    r_best;
    logic             r_found;
    logic [IW-1:0]    r_pred;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_has;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_ovf;

    logic             w_in_fire;
    logic             w_out_fire;
    logic             w_issue;
    logic             w_full;
    logic             w_load;
    logic             w_we;
    logic             w_hit;
    logic [DW-1:0]    w_rdata;
    logic [RW-1:0]    w_rd_rank;
    logic [BW-1:0]    w_cand;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_fire  = r_out_valid && o_out.ready;
    assign w_issue     = (r_state == S_SCAN) && (r_issue < r_count);
    assign w_full      = (r_count == CW'(MAX_ITEMS));
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign w_we        = w_load && !w_full;
    assign w_rd_rank   = w_rdata[DW-1 -: RW];
    assign w_cand      = {1'b0, w_rdata[LEN_W-1:0]} + BW'(1);
    assign w_hit       = r_pend && (w_rd_rank < r_cur) && (w_cand > r_best);

    assign o_out.valid        = r_out_valid;
    assign o_out.chain_length = r_out_len;
    assign o_out.has_prev     = r_out_has;
    assign o_out.prev_index   = r_out_idx;
    assign o_out.overflow     = r_out_ovf;

    lcl_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[IW-1:0]),
        .i_wdata({r_cur, r_best[LEN_W-1:0]}),
        .i_raddr(r_issue[IW-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (i_in.first_item || r_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_issue;
            if (w_in_fire) begin
                r_issue <= '0;
                if (i_in.first_item) begin
                    r_count <= '0;
                end
            end else if (w_issue) begin
                r_issue <= r_issue + CW'(1);
            end
            if (w_we) begin
                r_count <= r_count + CW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_issue[IW-1:0];
        if (w_in_fire) begin
            r_cur   <= i_in.rank[RW-1:0];
            r_best  <= BW'(1);
            r_found <= 1'b0;
            r_pred  <= '0;
        end else if (w_hit) begin
            r_best  <= w_cand;
            r_found <= 1'b1;
            r_pred  <= r_pidx;
        end
        if (w_load) begin
            r_out_len <= r_best[LEN_W-1:0];
            r_out_has <= r_found;
            r_out_idx <= IDX_W'(r_pred);
            r_out_ovf <= w_full;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("stored element count exceeds capacity");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN) && (CW'(r_pidx) < r_count))
        else $error("read data pending outside the scan range");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.first_item) |=> (r_count == '0) && (r_state == S_DONE))
        else $error("first item did not start an empty sequence");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_DONE) && !r_pend)
        else $error("store written while a scan is in flight");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> !$rose(r_out_valid) && $stable(r_out_len))
        else $error("held result overwritten");
`endif

endmodule
